>>> hw/rtl/crc32fc_pkg.sv
// ----------------------------------------------------------------------------
// crc32fc_pkg
// Shared constants, the result type, the bytewise CRC-32 update and a byte swap.
// ----------------------------------------------------------------------------
`default_nettype none

package crc32fc_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] SEED_AT_RST  = 32'hDEAD_AFFE;
    localparam int          BYTE_BITS    = 8;

    // One result beat
    typedef struct packed {
        logic [31:0] frame_crc;
        logic        crc_match;
    } t_result;

    // MSB-first CRC-32 over one byte, no reflection
    function automatic logic [31:0] crc_feed_byte(
        input logic [31:0] crc,
        input logic [7:0]  data
    );
        logic [31:0] c;
        c = crc ^ {data, 24'h0};
        for (int k = 0; k < BYTE_BITS; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Reverse byte order of a word
    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crc32fc_update.sv
// ----------------------------------------------------------------------------
// crc32fc_update
// Seed register and running CRC; builds the result beat on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32fc_update (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_acc,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_last_byte,
    input  wire logic [31:0]          i_received_crc,
    output logic                      o_res_vld,
    output crc32fc_pkg::t_result      o_res
);
    import crc32fc_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] n_seed;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] w_upd;
    logic [31:0] w_fin;

    // Bytewise update and final value
    assign w_upd = crc_feed_byte(r_crc, i_data_byte);
    assign w_fin = swap_bytes(w_upd);

    assign o_res_vld       = i_acc && i_last_byte;
    assign o_res.frame_crc = w_fin;
    assign o_res.crc_match = (w_fin == i_received_crc);

    // Next-state selection
    always_comb begin
        n_seed = i_cfg_we ? i_cfg_data : r_seed;
        n_crc  = r_crc;
        if (i_acc) begin
            n_crc = i_last_byte ? r_seed : w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_AT_RST;
            r_crc  <= SEED_AT_RST;
        end else begin
            r_seed <= n_seed;
            r_crc  <= n_crc;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/crc32fc_out_buf.sv
// ----------------------------------------------------------------------------
// crc32fc_out_buf
// Output register plus skid stage; decouples the result stall from input.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32fc_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire crc32fc_pkg::t_result i_res,
    output logic                      o_full,
    output logic                      o_vld,
    input  wire logic                 i_stall,
    output crc32fc_pkg::t_result      o_res
);
    import crc32fc_pkg::*;

    logic    r_out_vld;
    logic    n_out_vld;
    t_result r_out;
    t_result n_out;
    logic    r_skd_vld;
    logic    n_skd_vld;
    t_result r_skd;
    t_result n_skd;
    logic    w_pop;

    assign w_pop  = r_out_vld && !i_stall;
    assign o_full = r_skd_vld;
    assign o_vld  = r_out_vld;
    assign o_res  = r_out;

    // Skid holds a beat only while the output register is blocked
    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_skd_vld = r_skd_vld;
        n_skd     = r_skd;
        if (r_skd_vld) begin
            if (w_pop) begin
                n_out     = r_skd;
                n_skd_vld = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || w_pop) begin
                n_out     = i_res;
                n_out_vld = 1'b1;
            end else begin
                n_skd     = i_res;
                n_skd_vld = 1'b1;
            end
        end else if (w_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
        r_out <= n_out;
        r_skd <= n_skd;
    end

endmodule

`default_nettype wire

>>> hw/rtl/crc32_frame_check_core.sv
// ----------------------------------------------------------------------------
// crc32_frame_check_core
// Running CRC-32 (poly 04C11DB7, MSB-first) over frame bytes with check.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   data_byte, last_byte, received_crc
// out       source     o_out_valid / i_out_stall frame_crc, crc_match
// cfg       sink       i_cfg_valid / o_cfg_ready crc seed
//
// One byte beat per cycle unless stalled; the CRC update is one combinational step.
// The result enters the output or skid register when the last byte is accepted.
// Synchronous active-low reset: seed and running CRC go to 0xDEADAFFE.
// The output register plus skid stage keeps input flowing while a result waits;
// o_in_stall rises only when both the output and skid registers are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_frame_check_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [31:0] i_received_crc,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_frame_crc,
    output logic             o_crc_match
);
    import crc32fc_pkg::*;

    logic    w_acc;
    logic    w_full;
    logic    w_res_vld;
    t_result w_res;
    t_result w_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_acc       = i_in_valid && !w_full;

    // CRC datapath
    crc32fc_update u_update (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_acc          (w_acc),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_received_crc (i_received_crc),
        .o_res_vld      (w_res_vld),
        .o_res          (w_res)
    );

    // Result register with skid
    crc32fc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_vld),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_vld   (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_out)
    );

    assign o_frame_crc = w_out.frame_crc;
    assign o_crc_match = w_out.crc_match;

endmodule

`default_nettype wire
